[src/wrh_pkg.sv]
// Shared constants, types and codes of the wind-rose histogram.
`default_nettype none
package wrh_pkg;

  // Histogram geometry
  localparam int SECTOR_COUNT = 16;
  localparam int COUNT_BITS   = 32;
  localparam int SPEED_BINS   = 5;
  localparam int ENTRIES      = SECTOR_COUNT * SPEED_BINS;
  localparam int IDX_W        = $clog2(ENTRIES);
  localparam int SEC_W        = $clog2(SECTOR_COUNT);

  // Field widths
  localparam int OP_W      = 2;
  localparam int SPEED_W   = 16;
  localparam int DIR_W     = 16;
  localparam int RSEC_W    = 4;
  localparam int BIN_W     = 3;
  localparam int OSEC_W    = 4;
  localparam int OUT_CNT_W = 32;
  localparam int LIMIT_W   = 15;
  localparam int CFG_IDX_W = 2;

  // Direction reduction: one full turn in sixteenths of a degree
  localparam int FULL_TURN = 5760;
  localparam int WRAP_W    = $clog2(FULL_TURN);
  localparam int TURNS_W   = $clog2((1 << DIR_W) / FULL_TURN + 1);

  // Reciprocal of a full turn, exact floor for every 16-bit direction
  localparam int     TURN_SHIFT = 29;
  localparam longint TURN_RECIP = ((longint'(1) << TURN_SHIFT) + FULL_TURN - 1) / FULL_TURN;
  localparam int     TURN_RECIP_W = $clog2(TURN_RECIP + 1);

  // SECTOR_COUNT / FULL_TURN, exact floor for every wrapped direction
  localparam int     SECT_SHIFT = 26;
  localparam longint SECT_RECIP =
      ((longint'(SECTOR_COUNT) << SECT_SHIFT) + FULL_TURN - 1) / FULL_TURN;
  localparam int     SECT_RECIP_W = $clog2(SECT_RECIP + 1);

  // Speed limit reset values, sixteenths of m/s
  localparam logic [LIMIT_W-1:0] LIMIT_LOW_RST  = LIMIT_W'(80);
  localparam logic [LIMIT_W-1:0] LIMIT_MID_RST  = LIMIT_W'(240);
  localparam logic [LIMIT_W-1:0] LIMIT_HIGH_RST = LIMIT_W'(400);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MID  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_HIGH = CFG_IDX_W'(2);

  // Speed bin codes
  localparam logic [BIN_W-1:0] BIN_CALM = BIN_W'(0);
  localparam logic [BIN_W-1:0] BIN_LOW  = BIN_W'(1);
  localparam logic [BIN_W-1:0] BIN_MID  = BIN_W'(2);
  localparam logic [BIN_W-1:0] BIN_HIGH = BIN_W'(3);
  localparam logic [BIN_W-1:0] BIN_GALE = BIN_W'(4);

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WRAP = 7'b0000010,
    S_SECT = 7'b0000100,
    S_READ = 7'b0001000,
    S_UPD  = 7'b0010000,
    S_ZERO = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_e;

endpackage
`default_nettype wire

[src/wrh_in_if.sv]
// Input channel of the wind-rose histogram: valid/ready plus one item.
`default_nettype none
interface wrh_in_if import wrh_pkg::*; ();
  logic                      valid;
  logic                      ready;
  op_e                       opcode;
  logic signed [SPEED_W-1:0] speed;
  logic [DIR_W-1:0]          direction;
  logic [RSEC_W-1:0]         read_sector;
  logic [BIN_W-1:0]          read_bin;

  modport source (output valid, opcode, speed, direction, read_sector, read_bin,
                  input ready);
  modport sink   (input valid, opcode, speed, direction, read_sector, read_bin,
                  output ready);
endinterface
`default_nettype wire

[src/wrh_out_if.sv]
// Result channel of the wind-rose histogram: valid/ready plus one result.
`default_nettype none
interface wrh_out_if import wrh_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OSEC_W-1:0]    sector;
  logic [BIN_W-1:0]     speed_bin;
  logic [OUT_CNT_W-1:0] count;
  logic                 saturated;

  modport source (output valid, sector, speed_bin, count, saturated, input ready);
  modport sink   (input valid, sector, speed_bin, count, saturated, output ready);
endinterface
`default_nettype wire

[src/wrh_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module wrh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 80
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[src/wind_rose_histogram.sv]
// Wind-rose histogram: counter memory, direction/speed binning and control.
// Steps: an add passes S_WRAP, S_SECT, S_READ and S_UPD, where its result is
// loaded into the output register; an in-range read passes S_READ and S_UPD;
// clear and other items pass S_ZERO. S_UPD and S_ZERO hold until the output
// register is free. One transaction in flight; an add spans two direction
// reduction steps plus the read-modify-write on the single counter RAM.
// Reset: limits return to 80/240/400; all counters read zero at once through
// one valid flop per entry (no clearing pass); clear takes effect the same way.
`default_nettype none
module wind_rose_histogram import wrh_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [LIMIT_W-1:0]   cfg_data_i,
  wrh_in_if.sink                    in_i,
  wrh_out_if.source                 out_o
);

  // ---------------------------------------------------------------------
  // Configuration: three speed limits
  // ---------------------------------------------------------------------
  logic [LIMIT_W-1:0] limit_low_q, limit_mid_q, limit_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_low_q  <= LIMIT_LOW_RST;
      limit_mid_q  <= LIMIT_MID_RST;
      limit_high_q <= LIMIT_HIGH_RST;
    end else if (cfg_we_i) begin
      // an index past the list writes nothing
      if (cfg_idx_i == CFG_LIMIT_LOW) begin
        limit_low_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_LIMIT_MID) begin
        limit_mid_q <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_LIMIT_HIGH) begin
        limit_high_q <= cfg_data_i;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Control state and handshake
  // ---------------------------------------------------------------------
  state_e state_q, state_d;
  logic   in_acc;
  logic   out_free;
  logic   out_valid_q;
  logic   out_load;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  // the output register can take a new result this cycle
  assign out_free   = !out_valid_q || out_o.ready;

  // ---------------------------------------------------------------------
  // Speed classification, done on the incoming transaction.
  // Tests run in order, so misordered limits fall through the chain.
  // ---------------------------------------------------------------------
  logic signed [SPEED_W:0] spd_x, low_x, mid_x, high_x;
  logic [BIN_W-1:0]        bin_class;

  always_comb begin
    spd_x  = {in_i.speed[SPEED_W-1], in_i.speed};
    low_x  = $signed({2'b00, limit_low_q});
    mid_x  = $signed({2'b00, limit_mid_q});
    high_x = $signed({2'b00, limit_high_q});
    priority if (spd_x == '0) begin
      bin_class = BIN_CALM;
    end else if (spd_x > 0 && spd_x <= low_x) begin
      bin_class = BIN_LOW;
    end else if (spd_x > low_x && spd_x <= mid_x) begin
      bin_class = BIN_MID;
    end else if (spd_x > mid_x && spd_x <= high_x) begin
      bin_class = BIN_HIGH;
    end else begin
      bin_class = BIN_GALE;  // negative speeds land here too
    end
  end

  // ---------------------------------------------------------------------
  // Direction reduction, three registered steps:
  //   accept: turns = floor(direction / FULL_TURN) by reciprocal multiply
  //   S_WRAP: wrapped = direction - turns * FULL_TURN
  //   S_SECT: sector = floor(wrapped * SECTOR_COUNT / FULL_TURN)
  // ---------------------------------------------------------------------
  localparam int TPROD_W = DIR_W + TURN_RECIP_W;
  localparam int SPROD_W = WRAP_W + SECT_RECIP_W;

  logic [TPROD_W-1:0] turns_prod;
  logic [SPROD_W-1:0] sect_prod;
  logic [TURNS_W-1:0] turns_q;
  logic [WRAP_W-1:0]  wrapped_q;
  logic [DIR_W-1:0]   dir_q;

  assign turns_prod = TPROD_W'(in_i.direction) * TPROD_W'(TURN_RECIP);
  assign sect_prod  = SPROD_W'(wrapped_q) * SPROD_W'(SECT_RECIP);

  // Range check for a read address
  logic rd_in_range;
  assign rd_in_range = (int'(in_i.read_sector) < SECTOR_COUNT) &&
                       (int'(in_i.read_bin) < SPEED_BINS);

  // ---------------------------------------------------------------------
  // Transaction registers
  // ---------------------------------------------------------------------
  op_e               op_q;
  logic [SEC_W-1:0]  sec_q;
  logic [BIN_W-1:0]  bin_q;
  logic [RSEC_W-1:0] rsec_q;
  logic [BIN_W-1:0]  rbin_q;
  logic [IDX_W-1:0]  idx_q;

  // ---------------------------------------------------------------------
  // Counter memory and per-entry valid flops (invalid entry reads zero)
  // ---------------------------------------------------------------------
  logic [ENTRIES-1:0]    valid_q;
  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] cnt_cur, cnt_inc;

  assign ram_raddr = IDX_W'(int'(sec_q) * SPEED_BINS + int'(bin_q));
  assign ram_re    = (state_q == S_READ);
  assign ram_we    = (state_q == S_UPD) && out_free && (op_q == OP_ADD);

  assign cnt_cur = valid_q[idx_q] ? ram_rdata : '0;
  // saturate at all ones
  assign cnt_inc = (&cnt_cur) ? cnt_cur : cnt_cur + COUNT_BITS'(1);

  wrh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (ENTRIES)
  ) u_counters (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (cnt_inc),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_i.opcode)
            OP_ADD:   state_d = S_WRAP;
            OP_READ:  state_d = rd_in_range ? S_READ : S_ZERO;
            OP_CLEAR: state_d = S_ZERO;
            OP_NONE:  state_d = S_ZERO;
          endcase
        end
      end
      S_WRAP: state_d = S_SECT;
      S_SECT: state_d = S_READ;
      S_READ: state_d = S_UPD;
      S_UPD, S_ZERO: begin
        // hold until the output register frees up
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_load = (state_q == S_UPD || state_q == S_ZERO) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // clear drops every entry back to zero at once
      if (in_acc && in_i.opcode == OP_CLEAR) begin
        valid_q <= '0;
      end else if (ram_we) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers (no reset)
  // ---------------------------------------------------------------------
  logic [OSEC_W-1:0]    out_sec_q;
  logic [BIN_W-1:0]     out_bin_q;
  logic [OUT_CNT_W-1:0] out_cnt_q;
  logic                 out_sat_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= in_i.opcode;
      dir_q   <= in_i.direction;
      turns_q <= TURNS_W'(turns_prod >> TURN_SHIFT);
      rsec_q  <= in_i.read_sector;
      rbin_q  <= in_i.read_bin;
      sec_q   <= SEC_W'(in_i.read_sector);
      bin_q   <= (in_i.opcode == OP_ADD) ? bin_class : in_i.read_bin;
    end
    if (state_q == S_WRAP) begin
      wrapped_q <= WRAP_W'(dir_q - DIR_W'(int'(turns_q) * FULL_TURN));
    end
    if (state_q == S_SECT) begin
      sec_q <= SEC_W'(sect_prod >> SECT_SHIFT);
    end
    if (state_q == S_READ) begin
      idx_q <= ram_raddr;
    end
    if (out_load) begin
      if (state_q == S_UPD) begin
        out_sec_q <= OSEC_W'(sec_q);
        out_bin_q <= bin_q;
        if (op_q == OP_ADD) begin
          out_cnt_q <= OUT_CNT_W'(cnt_inc);
          out_sat_q <= &cnt_inc;
        end else begin
          out_cnt_q <= OUT_CNT_W'(cnt_cur);
          out_sat_q <= &cnt_cur;
        end
      end else begin
        // clear, unused opcode, or a read outside the histogram
        out_sec_q <= (op_q == OP_READ) ? rsec_q : '0;
        out_bin_q <= (op_q == OP_READ) ? rbin_q : '0;
        out_cnt_q <= '0;
        out_sat_q <= 1'b0;
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.sector    = out_sec_q;
  assign out_o.speed_bin = out_bin_q;
  assign out_o.count     = out_cnt_q;
  assign out_o.saturated = out_sat_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("input taken while a transaction is in flight");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.opcode == OP_CLEAR) |=> (valid_q == '0))
    else $error("clear left counters live");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_UPD || state_q == S_ZERO))
    else $error("result appeared outside a finishing step");

endmodule
`default_nettype wire
